>>> rtl/arfl_pkg.sv
// ----------------------------------------------------------------------------
// arfl_pkg
// Shared sizes, codes and the free-rectangle entry type for the atlas
// rectangle allocator.
// ----------------------------------------------------------------------------
package arfl_pkg;

    localparam int MAX_SPACES = 64;
    localparam int MAX_DIM    = 4096;

    localparam int AW = $clog2(MAX_SPACES);       // list address bits
    localparam int CW = $clog2(MAX_SPACES + 1);   // list count bits
    localparam int DW = 13;                       // dimension bits
    localparam int PW = 12;                       // coordinate bits
    localparam int NW = 3;                        // channel bits

    typedef struct packed {
        logic [PW-1:0] x;
        logic [PW-1:0] y;
        logic [DW-1:0] w;
        logic [DW-1:0] h;
    } t_rect;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_CHAN_ERR = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_CHANNELS = 2'd2;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        if (v == '0) begin
            return DW'(1);
        end else if (v > DW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return v;
    endfunction

endpackage

>>> rtl/atlas_rect_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// atlas_rect_free_list_allocator_unit
// First-fit guillotine allocator over a free list of atlas rectangles.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// request   in         i_valid / o_stall         i_req_width, i_req_height,
//                                                i_req_channels
// result    out        o_valid / i_stall         o_status, o_pos_x, o_pos_y,
//                                                o_free_count
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request at a time. The free list lives in a one-read, one-write memory
// with registered read data; the scan reads and then checks each entry
// visited, an exact-fit close-up reads and then writes each moved entry, and
// a split writes the new free rectangle, after which the insertion sort reads
// each key, then reads and compares the entries before it, moving each wider
// one up, and places the key. Reset and atlas size writes reinitialize the
// list (entry 0 is flagged as the whole atlas until written). A stalled
// result holds the sequencer in its final state; the next request is taken
// once it is loaded.
// ----------------------------------------------------------------------------
module atlas_rect_free_list_allocator_unit
    import arfl_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [DW-1:0] i_req_width,
    input  logic [DW-1:0] i_req_height,
    input  logic [NW-1:0] i_req_channels,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_status,
    output logic [PW-1:0] o_pos_x,
    output logic [PW-1:0] o_pos_y,
    output logic [CW-1:0] o_free_count,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [DW-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SH_RD, S_SH_WR, S_SPLIT,
        S_KEY_RD, S_KEY, S_CMP_RD, S_CMP, S_PLACE, S_DONE
    } t_state;

    t_state        r_state;
    logic [DW-1:0] r_atlas_w, r_atlas_h;
    logic [NW-1:0] r_atlas_ch;
    logic          r_init;
    logic          r_rd_init;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i, r_j;
    logic [DW-1:0] r_rw, r_rh;
    t_rect         r_hit;
    t_rect         r_key;
    t_rect         r_rd;
    logic [1:0]    r_res;
    logic [PW-1:0] r_px, r_py;

    t_rect         mem [MAX_SPACES];

    logic          rd_en_unused;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    t_rect         wd;
    t_rect         ent;
    logic          fits, wfit, hfit;
    logic          out_free;

    assign ent      = r_rd_init ? t_rect'{x: '0, y: '0, w: r_atlas_w, h: r_atlas_h} : r_rd;
    assign fits     = (r_rw <= ent.w) && (r_rh <= ent.h);
    assign wfit     = (r_rw == ent.w);
    assign hfit     = (r_rh == ent.h);
    assign out_free = !o_valid || !i_stall;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign rd_en_unused = 1'b0;

    always_comb begin
        case (r_state)
            S_SH_RD:  rd_addr = AW'(r_j + CW'(1));
            S_CMP_RD: rd_addr = AW'(r_j - CW'(1));
            default:  rd_addr = r_i[AW-1:0];
        endcase
    end

    // single write port
    always_comb begin
        we = 1'b0;
        wa = r_i[AW-1:0];
        wd = ent;
        case (r_state)
            S_SCAN_CHK: begin
                if (fits && !(wfit && hfit)) begin
                    if (wfit) begin
                        we   = 1'b1;
                        wd.y = PW'(ent.y + r_rh);
                        wd.h = ent.h - r_rh;
                    end else if (hfit || r_count < CW'(MAX_SPACES)) begin
                        we   = 1'b1;
                        wd.x = PW'(ent.x + r_rw);
                        wd.w = ent.w - r_rw;
                    end
                end
            end
            S_SH_WR: begin
                we = 1'b1;
                wa = r_j[AW-1:0];
            end
            S_SPLIT: begin
                we = 1'b1;
                wa = r_count[AW-1:0];
                wd = t_rect'{x: r_hit.x, y: PW'(r_hit.y + r_rh), w: r_rw,
                             h: r_hit.h - r_rh};
            end
            S_CMP: begin
                we = (ent.w > r_key.w);
                wa = r_j[AW-1:0];
            end
            S_PLACE: begin
                we = 1'b1;
                wa = r_j[AW-1:0];
                wd = r_key;
            end
            default: begin
                we = rd_en_unused;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_atlas_w  <= DW'(1024);
            r_atlas_h  <= DW'(1024);
            r_atlas_ch <= NW'(4);
            r_init     <= 1'b1;
            r_rd_init  <= 1'b0;
            r_count    <= CW'(1);
            o_valid    <= 1'b0;
        end else begin
            r_rd_init <= r_init && (rd_addr == '0);
            if (we && wa == '0) begin
                r_init <= 1'b0;
            end
            if (o_valid && !i_stall && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            CFG_WIDTH: begin
                                r_atlas_w <= clamp_dim(i_cfg_data);
                                r_init    <= 1'b1;
                                r_count   <= CW'(1);
                            end
                            CFG_HEIGHT: begin
                                r_atlas_h <= clamp_dim(i_cfg_data);
                                r_init    <= 1'b1;
                                r_count   <= CW'(1);
                            end
                            CFG_CHANNELS: r_atlas_ch <= i_cfg_data[NW-1:0];
                            default: ;
                        endcase
                    end
                    if (i_valid) begin
                        r_rw  <= i_req_width;
                        r_rh  <= i_req_height;
                        r_i   <= '0;
                        r_px  <= '0;
                        r_py  <= '0;
                        if (i_req_channels != r_atlas_ch) begin
                            r_res   <= ST_CHAN_ERR;
                            r_state <= S_DONE;
                        end else if (i_req_width == '0 || i_req_height == '0
                                     || r_count == '0) begin
                            r_res   <= ST_NO_FIT;
                            r_state <= S_DONE;
                        end else begin
                            r_res   <= ST_NO_FIT;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    r_hit <= ent;
                    if (fits) begin
                        if (wfit && hfit) begin
                            r_px    <= ent.x;
                            r_py    <= ent.y;
                            r_res   <= ST_PLACED;
                            r_count <= r_count - CW'(1);
                            r_j     <= r_i;
                            r_state <= (r_i + CW'(1) < r_count) ? S_SH_RD : S_DONE;
                        end else if (!wfit && !hfit && r_count >= CW'(MAX_SPACES)) begin
                            // position already zero from the request
                            r_res   <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_px    <= ent.x;
                            r_py    <= ent.y;
                            r_res   <= ST_PLACED;
                            r_state <= (!wfit && !hfit) ? S_SPLIT : S_DONE;
                        end
                    end else if (r_i + CW'(1) >= r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end
                // close up after an exact fit; r_count is already one less
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_j <= r_j + CW'(1);
                    if (r_j + CW'(1) < r_count) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SPLIT: begin
                    r_count <= r_count + CW'(1);
                    r_i     <= CW'(1);
                    r_state <= S_KEY_RD;
                end
                // stable insertion sort by width
                S_KEY_RD: r_state <= S_KEY;
                S_KEY: begin
                    r_key   <= ent;
                    r_j     <= r_i;
                    r_state <= S_CMP_RD;
                end
                S_CMP_RD: r_state <= S_CMP;
                S_CMP: begin
                    if (ent.w > r_key.w) begin
                        r_j <= r_j - CW'(1);
                        if (r_j == CW'(1)) begin
                            r_state <= S_PLACE;
                        end else begin
                            r_state <= S_CMP_RD;
                        end
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_i <= r_i + CW'(1);
                    if (r_i + CW'(1) < r_count) begin
                        r_state <= S_KEY_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid      <= 1'b1;
                        o_status     <= r_res;
                        o_pos_x      <= r_px;
                        o_pos_y      <= r_py;
                        o_free_count <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SPACES))
        else $error("free list count overflow");
    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_PLACED |-> o_pos_x == '0 && o_pos_y == '0)
        else $error("unplaced request with nonzero position");
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken without going busy");
`endif

endmodule
